FILE: rtl/core/ips_pkg.sv
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types and constants for the IPS patch stream parser.
// ----------------------------------------------------------------------------
package ips_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OFFSET,
        PH_LENGTH,
        PH_LITERAL,
        PH_RLE,
        PH_TRUNC,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        EV_WRITE    = 2'd0,
        EV_TRUNCATE = 2'd1,
        EV_HDR_ERR  = 2'd2,
        EV_END      = 2'd3
    } event_t;

    localparam logic [23:0] EOF_MARK = 24'h454F46;
    localparam int unsigned HDR_LEN  = 5;
    localparam int unsigned OFS_LEN  = 3;
    localparam int unsigned LEN_LEN  = 2;

    typedef struct packed {
        logic        valid;
        event_t      ev;
        logic [23:0] addr;
        logic [15:0] count;
        logic [7:0]  fill;
    } result_t;

    // "PATCH"
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h50;
                3'd1:    c = 8'h41;
                3'd2:    c = 8'h54;
                3'd3:    c = 8'h43;
                3'd4:    c = 8'h48;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

FILE: rtl/core/ips_in_reg.sv
// ----------------------------------------------------------------------------
// ips_in_reg
// Input register: holds one patch byte and its restart flag until the parser
// takes it.
// ----------------------------------------------------------------------------
module ips_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_restart,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_restart
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       restart_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg    <= in_byte;
            restart_reg <= in_restart;
        end
    end

    assign held_valid   = valid_reg;
    assign held_byte    = byte_reg;
    assign held_restart = restart_reg;

endmodule

FILE: rtl/core/ips_parse_core.sv
// ----------------------------------------------------------------------------
// ips_parse_core
// Parser state and the per-byte update: header check, record fields, literal
// and RLE runs, end marker and truncate length.
// ----------------------------------------------------------------------------
module ips_parse_core
    import ips_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic       restart,
    output result_t    result
);

    phase_t      phase_reg,  phase_next;
    logic [2:0]  idx_reg,    idx_next;
    logic [23:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] remain_reg, remain_next;
    logic [23:0] cursor_reg, cursor_next;

    phase_t      ph;
    logic [2:0]  idx;
    logic [23:0] ofs;
    logic [15:0] len;
    logic [15:0] rem;
    logic [23:0] cur;
    logic [23:0] ofs_shift;
    logic [15:0] len_shift;
    logic [15:0] rem_dec;

    always_comb
    begin
        // restart puts the state back to reset before this byte is taken
        ph  = restart ? PH_HEADER : phase_reg;
        idx = restart ? 3'd0  : idx_reg;
        ofs = restart ? 24'd0 : offset_reg;
        len = restart ? 16'd0 : length_reg;
        rem = restart ? 16'd0 : remain_reg;
        cur = restart ? 24'd0 : cursor_reg;

        ofs_shift = (idx == 3'd0) ? {16'd0, byte_in} : {ofs[15:0], byte_in};
        len_shift = (idx == 3'd0) ? {8'd0, byte_in}  : {len[7:0], byte_in};
        rem_dec   = (rem != 16'd0) ? rem - 16'd1 : rem;

        phase_next  = ph;
        idx_next    = idx;
        offset_next = ofs;
        length_next = len;
        remain_next = rem;
        cursor_next = cur;

        result       = '0;
        result.ev    = EV_WRITE;

        unique case (ph)
            PH_HEADER:
            begin
                if (byte_in != hdr_char(idx))
                begin
                    phase_next   = PH_ERROR;
                    idx_next     = 3'd0;
                    result.valid = 1'b1;
                    result.ev    = EV_HDR_ERR;
                end
                else if (idx == 3'(HDR_LEN - 1))
                begin
                    idx_next   = 3'd0;
                    phase_next = PH_OFFSET;
                end
                else
                begin
                    idx_next = idx + 3'd1;
                end
            end
            PH_OFFSET:
            begin
                offset_next = ofs_shift;
                if (idx == 3'(OFS_LEN - 1))
                begin
                    idx_next = 3'd0;
                    if (ofs_shift == EOF_MARK)
                    begin
                        phase_next   = PH_TRUNC;
                        result.valid = 1'b1;
                        result.ev    = EV_END;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                else
                begin
                    idx_next = idx + 3'd1;
                end
            end
            PH_LENGTH:
            begin
                length_next = len_shift;
                if (idx == 3'(LEN_LEN - 1))
                begin
                    idx_next = 3'd0;
                    if (len_shift != 16'd0)
                    begin
                        remain_next = len_shift;
                        cursor_next = ofs;
                        phase_next  = PH_LITERAL;
                    end
                    else
                    begin
                        phase_next = PH_RLE;
                    end
                end
                else
                begin
                    idx_next = idx + 3'd1;
                end
            end
            PH_LITERAL:
            begin
                cursor_next = cur + 24'd1;
                remain_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    phase_next = PH_OFFSET;
                end
                result.valid = 1'b1;
                result.ev    = EV_WRITE;
                result.addr  = cur;
                result.count = 16'd1;
                result.fill  = byte_in;
            end
            PH_RLE:
            begin
                if (idx < 3'(LEN_LEN))
                begin
                    length_next = len_shift;
                    idx_next    = idx + 3'd1;
                end
                else
                begin
                    idx_next   = 3'd0;
                    phase_next = PH_OFFSET;
                    if (len != 16'd0)
                    begin
                        result.valid = 1'b1;
                        result.ev    = EV_WRITE;
                        result.addr  = ofs;
                        result.count = len;
                        result.fill  = byte_in;
                    end
                end
            end
            PH_TRUNC:
            begin
                offset_next = ofs_shift;
                if (idx == 3'(OFS_LEN - 1))
                begin
                    idx_next     = 3'd0;
                    phase_next   = PH_DONE;
                    result.valid = 1'b1;
                    result.ev    = EV_TRUNCATE;
                    result.addr  = ofs_shift;
                end
                else
                begin
                    idx_next = idx + 3'd1;
                end
            end
            PH_DONE, PH_ERROR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            idx_reg    <= 3'd0;
            offset_reg <= 24'd0;
            length_reg <= 16'd0;
            remain_reg <= 16'd0;
            cursor_reg <= 24'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
            cursor_reg <= cursor_next;
        end
    end

endmodule

FILE: rtl/core/ips_out_reg.sv
// ----------------------------------------------------------------------------
// ips_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ips_out_reg
    import ips_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res_in,
    output logic        full,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = (load && res_in.valid) || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_in.valid)
        begin
            res_reg <= res_in;
        end
    end

    assign full     = valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.fill, res_reg.count, res_reg.addr};
    assign m_tuser  = res_reg.ev;

endmodule

FILE: rtl/core/ips_patch_stream_parser.sv
// ----------------------------------------------------------------------------
// ips_patch_stream_parser
// IPS patch parser: turns a patch byte stream into write, truncate, header
// error and end-of-records items.
// ----------------------------------------------------------------------------
// Slave channel: one patch byte per item in s_tdata, s_tuser set on the first
// byte of a new patch (it resets the parser before that byte is parsed).
// Master channel: one item per literal byte, RLE run, truncate, header
// error or end of records; m_tuser carries the kind, m_tdata address,
// count and fill byte. Bytes that produce nothing are consumed silently.
// Path: an accepted byte sits in the input register, and its result is
// then loaded into the result register, which drives m_tvalid.
// Throughput: one byte per cycle while m_tready is high or no result waits;
// the state update is one logic pass between input and result registers.
// Stall: while a result waits and m_tready is low, the input register holds
// one further byte and s_tready drops once it is occupied.
// Reset: the parser expects the first header byte; both registers empty.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser
    import ips_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] patch_byte
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] target_address, [39:24] run_count,
                                   // [47:40] fill_value
    output logic [1:0]  m_tuser    // [1:0] event_res
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_restart;
    logic       out_full;
    logic       step;
    result_t    result;

    assign step = held_valid && (!out_full || m_tready);

    ips_in_reg u_in_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .in_restart   (s_tuser),
        .take         (step),
        .held_valid   (held_valid),
        .held_byte    (held_byte),
        .held_restart (held_restart)
    );

    ips_parse_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (held_byte),
        .restart (held_restart),
        .result  (result)
    );

    ips_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res_in   (result),
        .full     (out_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
